// ----- hdl/quaternion_vector_rotate_macros.svh -----
// Assertion macros for the checker file of the rotate block.
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define QVR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/qvr_pkg.sv -----
// Types and constants of the quaternion vector rotate block.
package qvr_pkg;

	localparam int VEC_WIDTH  = 16;
	localparam int QUAT_FRAC  = 15;
	localparam int QUAT_WIDTH = QUAT_FRAC + 1;
	// exact quaternion product, then a matrix coefficient (sum of two doubled, or of four)
	localparam int PROD_WIDTH = 2 * QUAT_WIDTH;
	localparam int COEF_WIDTH = 2 * QUAT_WIDTH + 2;
	// coefficient split into an unsigned low half and a signed high half
	localparam int PLO_WIDTH  = QUAT_WIDTH + 1 + VEC_WIDTH;
	localparam int PHI_WIDTH  = COEF_WIDTH - QUAT_WIDTH + VEC_WIDTH;
	// three coefficient * vector terms per row
	localparam int ACC_WIDTH  = COEF_WIDTH + VEC_WIDTH + 2;
	localparam int RSHIFT     = 2 * QUAT_FRAC;

	localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0]  vec_x;
		logic signed [VEC_WIDTH-1:0]  vec_y;
		logic signed [VEC_WIDTH-1:0]  vec_z;
		logic signed [QUAT_WIDTH-1:0] quat_w;
		logic signed [QUAT_WIDTH-1:0] quat_x;
		logic signed [QUAT_WIDTH-1:0] quat_y;
		logic signed [QUAT_WIDTH-1:0] quat_z;
	} in_t;

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0] rot_x;
		logic signed [VEC_WIDTH-1:0] rot_y;
		logic signed [VEC_WIDTH-1:0] rot_z;
		logic                        clipped;
	} out_t;

endpackage

// ----- hdl/quaternion_vector_rotate.sv -----
// Quaternion vector rotation: five-stage pipeline computing q*(0,v)*conj(q).
//
// Input channel in_valid/in_ready/in_data carries a signed vector and a
// Q1.15 quaternion; output channel out_valid/out_ready/out_data returns the
// rotated vector, rounded half up, saturated, with a clip flag.
// The quaternion is used as given: a non-unit q also scales by |q|^2.
// Each item passes the stage registers s1 to s5 in order; out_valid is the
// s5 valid bit. Throughput: one item per cycle while out_ready is high.
// Stages are
//   s1 ten quaternion products, s2 rotation matrix coefficients,
//   s3 coefficient * vector products (each coefficient split in two halves),
//   s4 row sums plus rounding half, s5 shift, saturate, output register.
// Each stage holds its item while the next stage is full and stalled, so a
// stalled receiver fills the pipeline; in_ready drops only once all five
// stages hold items and out_ready is low. Bubbles are squeezed out.
// Reset clears all valid bits; no result is pending after reset.
module quaternion_vector_rotate (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  qvr_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output qvr_pkg::out_t out_data
);

	localparam int VW  = qvr_pkg::VEC_WIDTH;
	localparam int QW  = qvr_pkg::QUAT_WIDTH;
	localparam int PW  = qvr_pkg::PROD_WIDTH;
	localparam int CW  = qvr_pkg::COEF_WIDTH;
	localparam int LW  = qvr_pkg::PLO_WIDTH;
	localparam int HW  = qvr_pkg::PHI_WIDTH;
	localparam int AW  = qvr_pkg::ACC_WIDTH;
	localparam int RS  = qvr_pkg::RSHIFT;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (RS - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// s1: quaternion products
	logic signed [PW-1:0] p_ww_s1, p_xx_s1, p_yy_s1, p_zz_s1, p_xy_s1;
	logic signed [PW-1:0] p_wz_s1, p_xz_s1, p_wy_s1, p_yz_s1, p_wx_s1;
	logic signed [VW-1:0] vec_s1 [3];

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			p_ww_s1   <= in_data.quat_w * in_data.quat_w;
			p_xx_s1   <= in_data.quat_x * in_data.quat_x;
			p_yy_s1   <= in_data.quat_y * in_data.quat_y;
			p_zz_s1   <= in_data.quat_z * in_data.quat_z;
			p_xy_s1   <= in_data.quat_x * in_data.quat_y;
			p_wz_s1   <= in_data.quat_w * in_data.quat_z;
			p_xz_s1   <= in_data.quat_x * in_data.quat_z;
			p_wy_s1   <= in_data.quat_w * in_data.quat_y;
			p_yz_s1   <= in_data.quat_y * in_data.quat_z;
			p_wx_s1   <= in_data.quat_w * in_data.quat_x;
			vec_s1[0] <= in_data.vec_x;
			vec_s1[1] <= in_data.vec_y;
			vec_s1[2] <= in_data.vec_z;
		end
	end

	// s2: rotation matrix, row major
	logic signed [CW-1:0] coef_d [9];
	logic signed [CW-1:0] coef_s2 [9];
	logic signed [VW-1:0] vec_s2 [3];

	always_comb begin
		coef_d[0] = CW'(p_ww_s1) + CW'(p_xx_s1) - CW'(p_yy_s1) - CW'(p_zz_s1);
		coef_d[1] = (CW'(p_xy_s1) - CW'(p_wz_s1)) <<< 1;
		coef_d[2] = (CW'(p_xz_s1) + CW'(p_wy_s1)) <<< 1;
		coef_d[3] = (CW'(p_xy_s1) + CW'(p_wz_s1)) <<< 1;
		coef_d[4] = CW'(p_ww_s1) - CW'(p_xx_s1) + CW'(p_yy_s1) - CW'(p_zz_s1);
		coef_d[5] = (CW'(p_yz_s1) - CW'(p_wx_s1)) <<< 1;
		coef_d[6] = (CW'(p_xz_s1) - CW'(p_wy_s1)) <<< 1;
		coef_d[7] = (CW'(p_yz_s1) + CW'(p_wx_s1)) <<< 1;
		coef_d[8] = CW'(p_ww_s1) - CW'(p_xx_s1) - CW'(p_yy_s1) + CW'(p_zz_s1);
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			coef_s2 <= coef_d;
			vec_s2  <= vec_s1;
		end
	end

	// s3: coefficient halves times vector components
	logic signed [LW-1:0] plo_s3 [9];
	logic signed [HW-1:0] phi_s3 [9];

	for (genvar k = 0; k < 9; k++) begin : g_mul
		logic signed [QW:0]      c_lo;
		logic signed [CW-QW-1:0] c_hi;

		assign c_lo = {1'b0, coef_s2[k][QW-1:0]};
		assign c_hi = coef_s2[k][CW-1:QW];

		always_ff @(posedge clk) begin
			if (en3 && v_s2) begin
				plo_s3[k] <= c_lo * vec_s2[k % 3];
				phi_s3[k] <= c_hi * vec_s2[k % 3];
			end
		end
	end

	// s4: row sums with the rounding half folded in
	logic signed [AW-1:0] acc_d [3];
	logic signed [AW-1:0] acc_s4 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_d[r] = HALF;
			for (int c = 0; c < 3; c++) begin
				acc_d[r] = acc_d[r] + (AW'(phi_s3[3*r+c]) <<< QW) + AW'(plo_s3[3*r+c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) acc_s4 <= acc_d;
	end

	// s5: scale, saturate
	logic signed [AW-1:0] sh   [3];
	logic signed [VW-1:0] sat  [3];
	logic         [2:0]   clip;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sh[r] = acc_s4[r] >>> RS;
			if ((&sh[r][AW-1:VW-1]) || !(|sh[r][AW-1:VW-1])) begin
				sat[r]  = sh[r][VW-1:0];
				clip[r] = 1'b0;
			end else begin
				sat[r]  = sh[r][AW-1] ? qvr_pkg::VEC_MIN : qvr_pkg::VEC_MAX;
				clip[r] = 1'b1;
			end
		end
	end

	qvr_pkg::out_t res_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			res_s5.rot_x   <= sat[0];
			res_s5.rot_y   <= sat[1];
			res_s5.rot_z   <= sat[2];
			res_s5.clipped <= |clip;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

// ----- hdl/qvr_checker.sv -----
// Port-level checks of the quaternion vector rotate block, bound to its top level.
`include "quaternion_vector_rotate_macros.svh"

module qvr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input qvr_pkg::out_t out_data
);

	logic any_ext;

	assign any_ext = out_data.rot_x == qvr_pkg::VEC_MAX || out_data.rot_x == qvr_pkg::VEC_MIN ||
		out_data.rot_y == qvr_pkg::VEC_MAX || out_data.rot_y == qvr_pkg::VEC_MIN ||
		out_data.rot_z == qvr_pkg::VEC_MAX || out_data.rot_z == qvr_pkg::VEC_MIN;

	// a stalled result holds
	`QVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	// back pressure only when the output itself is stalled
	`QVR_ASSERT(a_ready_stall, (!in_ready |-> (out_valid && !out_ready)), "in_ready low without output stall")
	// a clip flag needs a saturated component
	`QVR_ASSERT(a_clip_ext, ((out_valid && out_data.clipped) |-> any_ext), "clipped set but no component at a limit")
	// no component at a limit means no clip
	`QVR_ASSERT(a_noext_noclip, ((out_valid && !any_ext) |-> !out_data.clipped), "clipped set with all components in range")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- dv/tb_top.sv -----
// Testbench for the quaternion vector rotate block, with its own exact rotation predictor.
`timescale 1ns / 1ps

module tb_top;
	import qvr_pkg::*;

	localparam int WIDE = 96;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	out_t rotated_q[$];
	int   errors    = 0;
	bit   idle_on   = 1'b0;
	bit   stall_on  = 1'b0;

	quaternion_vector_rotate uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("quaternion_vector_rotate test failed");
		$finish;
	end

	// q*(0,v)*conj(q), exact, then round half up and saturate per component
	function automatic out_t rotate_vector(input in_t d);
		logic signed [WIDE-1:0] w, x, y, z, vx, vy, vz;
		logic signed [WIDE-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		logic signed [WIDE-1:0] acc [3];
		logic signed [WIDE-1:0] half, vmax, vmin, s;
		logic signed [VEC_WIDTH-1:0] comp [3];
		logic clip;
		out_t r;
		w  = WIDE'(d.quat_w);
		x  = WIDE'(d.quat_x);
		y  = WIDE'(d.quat_y);
		z  = WIDE'(d.quat_z);
		vx = WIDE'(d.vec_x);
		vy = WIDE'(d.vec_y);
		vz = WIDE'(d.vec_z);
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		xy = x * y; xz = x * z; yz = y * z;
		wx = w * x; wy = w * y; wz = w * z;
		acc[0] = (ww + xx - yy - zz) * vx + (((xy - wz) * vy) <<< 1) +
			(((xz + wy) * vz) <<< 1);
		acc[1] = (((xy + wz) * vx) <<< 1) + (ww - xx + yy - zz) * vy +
			(((yz - wx) * vz) <<< 1);
		acc[2] = (((xz - wy) * vx) <<< 1) + (((yz + wx) * vy) <<< 1) +
			(ww - xx - yy + zz) * vz;
		half = WIDE'(1) <<< (RSHIFT - 1);
		vmax = WIDE'(VEC_MAX);
		vmin = WIDE'(VEC_MIN);
		clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			s = (acc[i] + half) >>> RSHIFT;
			if (s > vmax) begin
				comp[i] = VEC_MAX;
				clip = 1'b1;
			end else if (s < vmin) begin
				comp[i] = VEC_MIN;
				clip = 1'b1;
			end else begin
				comp[i] = s[VEC_WIDTH-1:0];
			end
		end
		r.rot_x   = comp[0];
		r.rot_y   = comp[1];
		r.rot_z   = comp[2];
		r.clipped = clip;
		return r;
	endfunction

	function automatic in_t make_item(input int vx, vy, vz, w, x, y, z);
		in_t d;
		d.vec_x  = vx[VEC_WIDTH-1:0];
		d.vec_y  = vy[VEC_WIDTH-1:0];
		d.vec_z  = vz[VEC_WIDTH-1:0];
		d.quat_w = w[QUAT_WIDTH-1:0];
		d.quat_x = x[QUAT_WIDTH-1:0];
		d.quat_y = y[QUAT_WIDTH-1:0];
		d.quat_z = z[QUAT_WIDTH-1:0];
		return d;
	endfunction

	// shift 0: full range; larger shifts shrink the quaternion toward zero
	function automatic logic [QUAT_WIDTH-1:0] rand_quat_part(input int shift);
		logic signed [QUAT_WIDTH-1:0] r;
		r = QUAT_WIDTH'($urandom);
		return r >>> shift;
	endfunction

	function automatic in_t rand_item();
		in_t d;
		int shift;
		case ($urandom_range(3))
			0: shift = 0;
			1, 2: shift = 1;  // |q|^2 <= 1, mostly no clipping
			default: shift = int'($urandom_range(2, 14));
		endcase
		d.vec_x  = VEC_WIDTH'($urandom);
		d.vec_y  = VEC_WIDTH'($urandom);
		d.vec_z  = VEC_WIDTH'($urandom);
		d.quat_w = rand_quat_part(shift);
		d.quat_x = rand_quat_part(shift);
		d.quat_y = rand_quat_part(shift);
		d.quat_z = rand_quat_part(shift);
		return d;
	endfunction

	// called right after a rising edge; returns right after the item is taken
	task automatic send_item(input in_t d);
		while (idle_on && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rotated_q.push_back(rotate_vector(d));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rotated_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= !stall_on || ($urandom_range(99) >= 23);
	end

	task automatic report_field(input string name, input logic signed [31:0] exp_v,
			input logic signed [31:0] got_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
		errors++;
	endtask

	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, got %h", $time, out_data);
				errors++;
			end else begin
				exp_r = rotated_q.pop_front();
				if (out_data.rot_x !== exp_r.rot_x)
					report_field("rot_x", 32'(exp_r.rot_x), 32'(out_data.rot_x));
				if (out_data.rot_y !== exp_r.rot_y)
					report_field("rot_y", 32'(exp_r.rot_y), 32'(out_data.rot_y));
				if (out_data.rot_z !== exp_r.rot_z)
					report_field("rot_z", 32'(exp_r.rot_z), 32'(out_data.rot_z));
				if (out_data.clipped !== exp_r.clipped)
					report_field("clipped", 32'(exp_r.clipped), 32'(out_data.clipped));
			end
		end
	end

	task automatic test_corner_cases();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		send_item(make_item(0, 0, 0, 0, 0, 0, 0));
		// -1.0 is exact in Q1.15, so this is the identity
		send_item(make_item(100, -200, 300, -32768, 0, 0, 0));
		send_item(make_item(32767, -32768, 32767, -32768, 0, 0, 0));
		send_item(make_item(32767, 32767, -32768, 32767, 0, 0, 0));
		// half turns about each axis
		send_item(make_item(1000, 2000, 3000, 0, -32768, 0, 0));
		send_item(make_item(1000, 2000, 3000, 0, 0, -32768, 0));
		send_item(make_item(1000, 2000, 3000, 0, 0, 0, -32768));
		// quarter turns about z and about x
		send_item(make_item(10000, 0, 0, 23170, 0, 0, 23170));
		send_item(make_item(-32768, 32767, -32768, 23170, 23170, 0, 0));
		// |q|^2 = 4: clipping both ways
		send_item(make_item(32767, -32768, 1, -32768, -32768, -32768, -32768));
		send_item(make_item(-32768, 32767, -32768, 32767, 32767, 32767, 32767));
		send_item(make_item(-32768, -32768, -32768, 32767, -32768, 32767, -32768));
		send_item(make_item(32767, 32767, 32767, -32768, 32767, -32768, 32767));
		// w = 0.5 scales by 1/4: exact halves round up
		send_item(make_item(2, -2, 6, 16384, 0, 0, 0));
		send_item(make_item(-6, 1, -1, 16384, 0, 0, 0));
		send_item(make_item(3, -3, -10, 16384, 0, 0, 0));
		send_item(make_item(32767, -32768, 12345, 1, 0, 0, 0));
		send_item(make_item(-1, -1, -1, -1, -1, -1, -1));
		send_item(make_item(32767, 32767, 32767, 0, 0, 0, 0));
	endtask

	task automatic test_random_rotations(input int count);
		idle_on  = 1'b1;
		stall_on = 1'b1;
		for (int i = 0; i < count; i++)
			send_item(rand_item());
	endtask

	task automatic test_drain_pause(input int count);
		idle_on  = 1'b1;
		stall_on = 1'b1;
		wait_drained();
		for (int i = 0; i < count; i++)
			send_item(rand_item());
	endtask

	task automatic test_back_to_back(input int count);
		idle_on  = 1'b0;
		stall_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_item(rand_item());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_random_rotations(250);
		test_drain_pause(50);
		test_back_to_back(150);
		test_random_rotations(150);
		wait_drained();
		stall_on = 1'b0;
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("quaternion_vector_rotate test passed");
		else
			$display("quaternion_vector_rotate test failed");
		$finish;
	end

endmodule
